// ----- rtl/drs_pkg.sv -----
// ----------------------------------------------------------------------------
// drs_pkg: shared types for the descending record sort
// Control word broadcast from the top level to every cell of the chain.
// ----------------------------------------------------------------------------
package drs_pkg;

    // per-cycle command to the cell chain
    typedef struct packed {
        logic ins;  // insert the broadcast record in order
        logic shl;  // shift contents one cell towards the head
    } t_cell_ctrl;

endpackage

// ----- rtl/drs_cell.sv -----
// ----------------------------------------------------------------------------
// drs_cell: one slot of the sorting chain
// Holds one record; on insert it keeps its record, takes the new one or takes
// its left neighbour's, on shift it takes its right neighbour's.
// ----------------------------------------------------------------------------
module drs_cell
    import drs_pkg::*;
#(
    parameter int KEY_BITS = 32,
    parameter int TAG_BITS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_cell_ctrl          i_ctrl,
    // broadcast record
    input  logic [KEY_BITS-1:0] i_new_key,
    input  logic [TAG_BITS-1:0] i_new_tag,
    // left neighbour (towards the head)
    input  logic                i_left_keep,
    input  logic                i_left_valid,
    input  logic [KEY_BITS-1:0] i_left_key,
    input  logic [TAG_BITS-1:0] i_left_tag,
    // right neighbour (towards the tail)
    input  logic                i_right_valid,
    input  logic [KEY_BITS-1:0] i_right_key,
    input  logic [TAG_BITS-1:0] i_right_tag,
    // own contents
    output logic                o_keep,
    output logic                o_valid,
    output logic [KEY_BITS-1:0] o_key,
    output logic [TAG_BITS-1:0] o_tag
);

    logic                r_valid;
    logic [KEY_BITS-1:0] r_key;
    logic [TAG_BITS-1:0] r_tag;
    logic                n_valid;
    logic [KEY_BITS-1:0] n_key;
    logic [TAG_BITS-1:0] n_tag;

    // equal keys stay ahead of the newcomer, so arrival order holds on ties
    assign o_keep = r_valid && (r_key >= i_new_key);

    // next contents
    always_comb begin
        n_valid = r_valid;
        n_key   = r_key;
        n_tag   = r_tag;
        if (i_ctrl.ins && !o_keep) begin
            if (i_left_keep) begin
                n_valid = 1'b1;
                n_key   = i_new_key;
                n_tag   = i_new_tag;
            end else begin
                n_valid = i_left_valid;
                n_key   = i_left_key;
                n_tag   = i_left_tag;
            end
        end else if (i_ctrl.shl) begin
            n_valid = i_right_valid;
            n_key   = i_right_key;
            n_tag   = i_right_tag;
        end
    end

    // occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // payload, no reset
    always_ff @(posedge i_clk) begin
        r_key <= n_key;
        r_tag <= n_tag;
    end

    assign o_valid = r_valid;
    assign o_key   = r_key;
    assign o_tag   = r_tag;

endmodule

// ----- rtl/descending_record_sort.sv -----
// ----------------------------------------------------------------------------
// descending_record_sort: collects a set of records, emits them by key
// Insertion chain of CAPACITY cells kept in descending key order.
// ----------------------------------------------------------------------------
// Usage:
//  Input channel (i_in_valid / o_in_stall) takes one record word per cycle:
//  key, tag and a final flag. Each word is slotted into the chain in the
//  cycle it is accepted, so loading runs at one word per clock.
//  The word with i_final_item set closes the set. The block then stalls its
//  input and drains the chain from the head through an output register, one
//  word per cycle (o_out_valid / i_out_stall). Accepting the final word sets
//  the drain flag (r_emit), and the first sorted word then passes from the
//  head cell into the output register. Equal keys leave in the order they
//  arrived. o_run_end marks the last word of the run.
//  Words arriving with all CAPACITY cells full are dropped; o_overflowed is
//  then set on every word of that run.
//  A stall on the output holds the output word and freezes the chain; the
//  input stays stalled until the run-end word has been loaded out.
//  Reset (synchronous, active low) empties the chain and clears the drop
//  flag; the block is ready to load in the first cycle after reset.
// ----------------------------------------------------------------------------
module descending_record_sort
    import drs_pkg::*;
#(
    parameter int CAPACITY = 64,
    parameter int KEY_BITS = 32,
    parameter int TAG_BITS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // record input
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic [KEY_BITS-1:0] i_count_key,
    input  logic [TAG_BITS-1:0] i_record_tag,
    input  logic                i_final_item,
    // sorted output
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic [KEY_BITS-1:0] o_sorted_key,
    output logic [TAG_BITS-1:0] o_sorted_tag,
    output logic                o_run_end,
    output logic                o_overflowed
);

    logic                w_keep  [CAPACITY];
    logic                w_valid [CAPACITY];
    logic [KEY_BITS-1:0] w_key   [CAPACITY];
    logic [TAG_BITS-1:0] w_tag   [CAPACITY];

    t_cell_ctrl w_ctrl;
    logic       w_in_acc;
    logic       w_full;
    logic       w_load;

    logic       r_emit;
    logic       n_emit;
    logic       r_drop;
    logic       n_drop;

    logic                r_out_valid;
    logic [KEY_BITS-1:0] r_out_key;
    logic [TAG_BITS-1:0] r_out_tag;
    logic                r_out_end;
    logic                r_out_ovf;

    // handshake and chain control
    assign o_in_stall  = r_emit;
    assign w_in_acc    = i_in_valid && !r_emit;
    assign w_full      = w_valid[CAPACITY-1];
    assign w_load      = r_emit && (!r_out_valid || !i_out_stall);
    assign w_ctrl.ins  = w_in_acc && !w_full;
    assign w_ctrl.shl  = w_load;

    // cell chain
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic                l_keep;
        logic                l_valid;
        logic [KEY_BITS-1:0] l_key;
        logic [TAG_BITS-1:0] l_tag;
        logic                r_valid_nb;
        logic [KEY_BITS-1:0] r_key_nb;
        logic [TAG_BITS-1:0] r_tag_nb;

        if (g == 0) begin : g_head
            assign l_keep  = 1'b1;
            assign l_valid = 1'b0;
            assign l_key   = '0;
            assign l_tag   = '0;
        end else begin : g_body
            assign l_keep  = w_keep[g-1];
            assign l_valid = w_valid[g-1];
            assign l_key   = w_key[g-1];
            assign l_tag   = w_tag[g-1];
        end

        if (g == CAPACITY - 1) begin : g_tail
            assign r_valid_nb = 1'b0;
            assign r_key_nb   = '0;
            assign r_tag_nb   = '0;
        end else begin : g_mid
            assign r_valid_nb = w_valid[g+1];
            assign r_key_nb   = w_key[g+1];
            assign r_tag_nb   = w_tag[g+1];
        end

        drs_cell #(
            .KEY_BITS (KEY_BITS),
            .TAG_BITS (TAG_BITS)
        ) u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_ctrl        (w_ctrl),
            .i_new_key     (i_count_key),
            .i_new_tag     (i_record_tag),
            .i_left_keep   (l_keep),
            .i_left_valid  (l_valid),
            .i_left_key    (l_key),
            .i_left_tag    (l_tag),
            .i_right_valid (r_valid_nb),
            .i_right_key   (r_key_nb),
            .i_right_tag   (r_tag_nb),
            .o_keep        (w_keep[g]),
            .o_valid       (w_valid[g]),
            .o_key         (w_key[g]),
            .o_tag         (w_tag[g])
        );
    end

    // drain mode and drop flag
    always_comb begin
        n_emit = r_emit;
        n_drop = r_drop;
        if (w_in_acc) begin
            n_drop = r_drop || w_full;
            n_emit = i_final_item;
        end else if (w_load && !w_valid[1]) begin
            // run-end word leaves the chain
            n_emit = 1'b0;
            n_drop = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_emit <= 1'b0;
            r_drop <= 1'b0;
        end else begin
            r_emit <= n_emit;
            r_drop <= n_drop;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_key <= w_key[0];
            r_out_tag <= w_tag[0];
            r_out_end <= !w_valid[1];
            r_out_ovf <= r_drop;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_sorted_key = r_out_key;
    assign o_sorted_tag = r_out_tag;
    assign o_run_end    = r_out_end;
    assign o_overflowed = r_out_ovf;

    // ------------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------------
    logic [CAPACITY-1:0] w_valid_vec;
    for (genvar v = 0; v < CAPACITY; v++) begin : g_vvec
        assign w_valid_vec[v] = w_valid[v];
    end

    // occupied cells form a prefix of the chain
    a_prefix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_valid_vec[CAPACITY-1:1] & ~w_valid_vec[CAPACITY-2:0]) == '0)
        else $error("chain occupancy has a gap");

    // head pair stays in descending order
    a_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_valid[1] |-> (w_key[0] >= w_key[1]))
        else $error("chain out of order at head");

    // draining never reads an empty head cell
    a_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_emit |-> w_valid[0])
        else $error("drain with empty chain");

    // loading the run-end word ends the drain
    a_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_load && !w_valid[1]) |=> (!r_emit && !w_valid[0] && !r_drop))
        else $error("drain did not finish after run end");

endmodule

// ----- tb/tb.sv -----
// ----------------------------------------------------------------------------
// tb: self-checking bench for descending_record_sort
// Sends sets of records over the input channel and predicts each sorted run
// with a behavioural insertion sort (ties kept in arrival order, extra words
// dropped once the store is full). Every sorted word is checked field by
// field. Directed sets, store-full sets, then random sets under several
// sender idle and receiver stall mixes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

    localparam int DEPTH       = 64;
    localparam int KEY_W       = 32;
    localparam int TAG_W       = 16;
    localparam int QUIET_LIMIT = 4000;
    localparam int SETTLE_CYC  = 8;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [TAG_W-1:0] tag;
    } record_t;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [TAG_W-1:0] tag;
        logic             run_end;
        logic             overflowed;
    } sorted_word_t;

    logic             i_clk        = 1'b0;
    logic             i_rst_n      = 1'b0;
    logic             i_in_valid   = 1'b0;
    logic             o_in_stall;
    logic [KEY_W-1:0] i_count_key  = '0;
    logic [TAG_W-1:0] i_record_tag = '0;
    logic             i_final_item = 1'b0;
    logic             o_out_valid;
    logic             i_out_stall  = 1'b0;
    logic [KEY_W-1:0] o_sorted_key;
    logic [TAG_W-1:0] o_sorted_tag;
    logic             o_run_end;
    logic             o_overflowed;

    // predictor state: records of the open set, in descending key order
    record_t      held_recs[$];
    logic         set_dropped = 1'b0;
    sorted_word_t sorted_due[$];

    int fault_count   = 0;
    int quiet_cycles  = 0;
    int in_idle_pct   = 0;
    int out_stall_pct = 0;

    descending_record_sort #(
        .CAPACITY (DEPTH),
        .KEY_BITS (KEY_W),
        .TAG_BITS (TAG_W)
    ) i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_count_key  (i_count_key),
        .i_record_tag (i_record_tag),
        .i_final_item (i_final_item),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_sorted_key (o_sorted_key),
        .o_sorted_tag (o_sorted_tag),
        .o_run_end    (o_run_end),
        .o_overflowed (o_overflowed)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    task automatic flag_fault(input string msg);
        fault_count++;
        if (fault_count <= 10) begin
            $display("%t: %s", $realtime, msg);
        end
    endtask

    // slot one accepted word into the held set; on the final word release
    // the whole run as expected sorted words
    function automatic void sort_in_record(input logic [KEY_W-1:0] key,
                                           input logic [TAG_W-1:0] tag,
                                           input logic fin);
        int      pos;
        record_t rec;
        rec = '{key: key, tag: tag};
        if (held_recs.size() < DEPTH) begin
            pos = 0;
            while (pos < held_recs.size() && held_recs[pos].key >= key) begin
                pos++;
            end
            held_recs.insert(pos, rec);
        end else begin
            set_dropped = 1'b1;
        end
        if (fin) begin
            foreach (held_recs[k]) begin
                sorted_due.push_back('{key: held_recs[k].key, tag: held_recs[k].tag,
                                       run_end: (k == held_recs.size() - 1),
                                       overflowed: set_dropped});
            end
            held_recs.delete();
            set_dropped = 1'b0;
        end
    endfunction

    // input monitor: predict on every accepted word
    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && !o_in_stall) begin
            sort_in_record(i_count_key, i_record_tag, i_final_item);
        end
    end

    // output monitor: compare each accepted sorted word with the oldest due
    always @(posedge i_clk) begin
        sorted_word_t got;
        sorted_word_t want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got = '{key: o_sorted_key, tag: o_sorted_tag,
                    run_end: o_run_end, overflowed: o_overflowed};
            if (sorted_due.size() == 0) begin
                flag_fault($sformatf("unexpected word key=%h tag=%h end=%b ovf=%b",
                                     got.key, got.tag, got.run_end, got.overflowed));
            end else begin
                want = sorted_due.pop_front();
                if (got !== want) begin
                    flag_fault($sformatf(
                        "mismatch exp key=%h tag=%h end=%b ovf=%b got key=%h tag=%h end=%b ovf=%b",
                        want.key, want.tag, want.run_end, want.overflowed,
                        got.key, got.tag, got.run_end, got.overflowed));
                end
            end
        end
    end

    // receiver back-pressure
    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < out_stall_pct);
    end

    // watchdog: too long without any word moving on either side
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("timeout: no word moved for %0d cycles", QUIET_LIMIT);
            $display("** descending_record_sort: FAILED **");
            $finish;
        end
    end

    // drive one record word and hold it until accepted
    task automatic send_rec(input logic [KEY_W-1:0] key, input logic [TAG_W-1:0] tag,
                            input logic fin);
        while ($urandom_range(99) < in_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_count_key  <= key;
        i_record_tag <= tag;
        i_final_item <= fin;
        @(posedge i_clk);
        while (o_in_stall) begin
            @(posedge i_clk);
        end
    endtask

    // let every due word arrive, then a few quiet cycles
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (sorted_due.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    // mostly wide random keys, with a share of ties, extremes and single bits
    function automatic logic [KEY_W-1:0] pick_key();
        case ($urandom_range(9))
            0, 1: return KEY_W'($urandom_range(3));
            2: begin
                case ($urandom_range(3))
                    0: return '0;
                    1: return '1;
                    2: return '1 - 1;
                    default: return KEY_W'(1);
                endcase
            end
            3: return KEY_W'(1) << $urandom_range(KEY_W - 1);
            default: return KEY_W'($urandom());
        endcase
    endfunction

    task automatic send_set(input int len);
        for (int n = 0; n < len; n++) begin
            send_rec(pick_key(), TAG_W'($urandom()), n == len - 1);
        end
    endtask

    // field extremes, order patterns and ties
    task automatic test_directed();
        in_idle_pct   = 0;
        out_stall_pct = 0;
        // single-word sets
        send_rec('0, '0, 1'b1);
        send_rec('1, '1, 1'b1);
        // ascending keys come out reversed
        send_rec(32'd1, 16'h0001, 1'b0);
        send_rec(32'd2, 16'h0002, 1'b0);
        send_rec(32'd3, 16'h0003, 1'b0);
        send_rec(32'd4, 16'h0004, 1'b1);
        // equal keys keep arrival order around a larger one
        send_rec(32'd5, 16'haaaa, 1'b0);
        send_rec(32'd5, 16'h5555, 1'b0);
        send_rec('1, 16'h00ff, 1'b0);
        send_rec(32'd5, 16'hff00, 1'b1);
        // extreme keys mixed, duplicated
        send_rec('1, 16'h1111, 1'b0);
        send_rec('0, 16'h2222, 1'b0);
        send_rec('1, 16'h3333, 1'b0);
        send_rec('0, 16'h4444, 1'b0);
        send_rec(32'h8000_0000, 16'h8000, 1'b0);
        send_rec(32'h7fff_ffff, 16'h7fff, 1'b1);
        // already descending with a tie
        send_rec(32'd9, 16'h0009, 1'b0);
        send_rec(32'd7, 16'h0007, 1'b0);
        send_rec(32'd7, 16'h0017, 1'b0);
        send_rec(32'd3, 16'h0003, 1'b1);
        wait_drained();
    endtask

    // exactly full store, then two sets whose tails (final word included) are dropped
    task automatic test_store_full();
        in_idle_pct   = 29;
        out_stall_pct = 29;
        send_set(DEPTH);
        send_set(DEPTH + 2);
        send_set(DEPTH + 1);
        wait_drained();
    endtask

    // random sets, mostly short, a few long, full or over-full
    task automatic test_random_sets(input int budget, input int idle_pct, input int stall_pct);
        int sent;
        int len;
        int pick;
        in_idle_pct   = idle_pct;
        out_stall_pct = stall_pct;
        sent = 0;
        while (sent < budget) begin
            pick = $urandom_range(99);
            if (pick < 70) begin
                len = $urandom_range(6, 1);
            end else if (pick < 90) begin
                len = $urandom_range(20, 7);
            end else if (pick < 98) begin
                len = $urandom_range(DEPTH, 21);
            end else begin
                len = $urandom_range(DEPTH + 4, DEPTH + 1);
            end
            send_set(len);
            sent += len;
        end
        wait_drained();
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_store_full();
        test_random_sets(60, 0, 0);
        test_random_sets(60, 50, 0);
        test_random_sets(60, 0, 50);
        test_random_sets(60, 29, 29);

        if (sorted_due.size() != 0) begin
            flag_fault($sformatf("%0d sorted words never arrived", sorted_due.size()));
        end
        if (fault_count == 0) begin
            $display("** descending_record_sort: PASSED **");
        end else begin
            $display("** descending_record_sort: FAILED **");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/drs_pkg.sv
rtl/drs_cell.sv
rtl/descending_record_sort.sv
tb/tb.sv
